[sv/shfm_pkg.sv]
// shared types and constants for the four-byte-mix string hash
// no dependencies; compiled before every other file of the block
package shfm_pkg;

  // width of the length field on the input channel
  localparam int LEN_FIELD_BITS = 24;
  // width of the length counters inside the block
  localparam int LENGTH_BITS = 24;
  // width of one string byte and of the hash
  localparam int BYTE_BITS = 8;
  localparam int HASH_BITS = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // one classified byte request handed from front to back
  typedef struct packed {
    logic                   seed;          // first item of a string: reseed accumulators
    logic [3:0]             seed_rem;      // length mod 13
    logic [LENGTH_BITS-1:0] seed_len;      // masked length
    logic                   proc;          // a byte is taken (not an empty string)
    logic [BYTE_BITS-1:0]   byte_value;
    logic [1:0]             pos;           // place of the byte in its group
    logic                   full;          // byte belongs to a full group with more bytes after it
    logic [LENGTH_BITS:0]   cnt;           // remaining count at this byte plus three
    logic                   emit;          // string ends with this request
    logic [LENGTH_BITS-1:0] total_length;
  } cmd_t;

endpackage

[sv/shfm_in_if.sv]
// input channel of the string hash: one string byte per request
// depends on shfm_pkg
interface shfm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                start_string;
  logic [shfm_pkg::LEN_FIELD_BITS-1:0] string_length;
  logic [shfm_pkg::BYTE_BITS-1:0]      byte_value;

  modport source (output valid, start_string, string_length, byte_value, input ready);
  modport sink (input valid, start_string, string_length, byte_value, output ready);
endinterface

[sv/shfm_out_if.sv]
// output channel of the string hash: one hash per finished string
// depends on shfm_pkg
interface shfm_out_if;
  logic                           valid;
  logic                           ready;
  logic [shfm_pkg::HASH_BITS-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

[sv/shfm_front.sv]
// front end: accepts bytes, tracks string position and classifies each byte
// depends on shfm_pkg and shfm_in_if
module shfm_front (
  input  logic            clk,
  input  logic            rst,
  shfm_in_if.sink         in_req,
  input  logic            q_full,
  output logic            push,
  output shfm_pkg::cmd_t  cmd
);
  import shfm_pkg::*;

  localparam int NIBBLES = (LENGTH_BITS + 3) / 4;

  // length mod 13 by folding nibbles: 16^i mod 13 runs through 1, 3, 9 in turn
  function automatic logic [3:0] mod13(input logic [LENGTH_BITS-1:0] v);
    logic [NIBBLES*4-1:0] w;
    logic [10:0]          sum;
    logic [10:0]          wt;
    logic [6:0]           f1;
    logic [5:0]           f2;
    w   = (NIBBLES*4)'(v);
    sum = '0;
    wt  = 11'd1;
    for (int i = 0; i < NIBBLES; i++) begin
      sum = sum + 11'(w[4*i +: 4]) * wt;
      wt  = (wt == 11'd9) ? 11'd1 : 11'(wt * 11'd3);
    end
    f1 = 7'(sum[10:4] * 7'd3) + 7'(sum[3:0]);
    f2 = 6'(6'(f1[6:4]) * 6'd3) + 6'(f1[3:0]);
    if (f2 >= 6'd26) begin
      f2 = f2 - 6'd26;
    end else if (f2 >= 6'd13) begin
      f2 = f2 - 6'd13;
    end
    return f2[3:0];
  endfunction

  logic [LENGTH_BITS-1:0] bytes_left;
  logic [LENGTH_BITS-1:0] total_length;
  logic [1:0]             group_position;

  logic                   start;
  logic                   take;
  logic                   live;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] bl_eff;
  logic [LENGTH_BITS-1:0] tl_eff;
  logic [1:0]             p_eff;

  assign in_req.ready = !q_full;
  assign take         = in_req.valid && in_req.ready;

  // pick the position the byte lands on: a start request always reseeds
  always_comb begin
    start  = in_req.start_string;
    len    = LENGTH_BITS'(32'(in_req.string_length));
    bl_eff = start ? len : bytes_left;
    tl_eff = start ? len : total_length;
    p_eff  = start ? 2'd0 : group_position;
    live   = start || (bytes_left != '0);
    push   = take && live;
  end

  // classify the byte for the back end
  always_comb begin
    cmd.seed         = start;
    cmd.seed_rem     = mod13(len);
    cmd.seed_len     = len;
    cmd.proc         = (bl_eff != '0);
    cmd.byte_value   = in_req.byte_value;
    cmd.pos          = p_eff;
    cmd.full         = ({1'b0, bl_eff} + (LENGTH_BITS+1)'(p_eff)) > (LENGTH_BITS+1)'(4);
    cmd.cnt          = {1'b0, bl_eff} + (LENGTH_BITS+1)'(3);
    cmd.emit         = (bl_eff == '0) || (bl_eff == LENGTH_BITS'(1));
    cmd.total_length = tl_eff;
  end

  // string position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left     <= '0;
      total_length   <= '0;
      group_position <= '0;
    end else if (push) begin
      total_length <= tl_eff;
      if (bl_eff != '0) begin
        bytes_left     <= bl_eff - LENGTH_BITS'(1);
        group_position <= p_eff + 2'd1;
      end else begin
        bytes_left     <= '0;
        group_position <= '0;
      end
    end
  end

  // a request with no byte work can only be an empty string, which ends at once
  a_empty_emits: assert property (@(posedge clk) disable iff (rst)
    (push && !cmd.proc) |-> (cmd.seed && cmd.emit))
    else $error("empty request without a hash");

  // a finished string leaves no bytes pending
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (push && cmd.emit) |=> (bytes_left == '0))
    else $error("bytes left after the last byte");

endmodule

[sv/shfm_queue.sv]
// short command queue between front and back ends
// depends on shfm_pkg
module shfm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  shfm_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output shfm_pkg::cmd_t  pop_data
);
  import shfm_pkg::*;

  cmd_t                      slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;

  assign full      = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CNT_BITS'(1);
        2'b01:   count <= count - QUEUE_CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("pop from an empty queue");

endmodule

[sv/shfm_back.sv]
// back end: group and tail mixing into two accumulators, final hash, output register
// depends on shfm_pkg and shfm_out_if
module shfm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  input  shfm_pkg::cmd_t  cmd,
  output logic            pop,
  shfm_out_if.source      out_res
);
  import shfm_pkg::*;

  localparam logic [31:0] FULL_A2_MUL  = 32'd509;
  localparam logic [31:0] FULL_S0_MUL  = 32'd307;
  localparam logic [31:0] FULL_S1_MUL  = 32'd1319;
  localparam logic [31:0] FULL_CNT_MUL = 32'd17;
  localparam logic [31:0] FULL_CNT_ADD = 32'd5;
  localparam logic [31:0] FULL_B2_MUL  = 32'd5309;
  localparam logic [31:0] FULL_S2_MUL  = 32'd3313;
  localparam logic [31:0] FULL_S3_MUL  = 32'd9337;
  localparam logic [31:0] FULL_S3_ADD  = 32'd517;
  localparam logic [31:0] T0_ACC_MUL   = 32'd7703;
  localparam logic [31:0] T0_S_MUL     = 32'd503;
  localparam logic [31:0] T1_ACC_MUL   = 32'd7717;
  localparam logic [31:0] T1_S_MUL     = 32'd509;
  localparam logic [31:0] T2_ACC_MUL   = 32'd9323;
  localparam logic [31:0] T2_ADD       = 32'd11;
  localparam logic [31:0] T2_S_MUL     = 32'd523;
  localparam logic [31:0] T3_ACC_MUL   = 32'd7727;
  localparam logic [31:0] T3_ACC_ADD   = 32'd127;
  localparam logic [31:0] T3_ADD       = 32'd313;
  localparam logic [31:0] T3_S_MUL     = 32'd547;
  localparam logic [31:0] FIN_A1_MUL   = 32'd29311;
  localparam logic [31:0] FIN_A1_ADD   = 32'd59;
  localparam logic [31:0] FIN_A2_MUL   = 32'd7321;
  localparam logic [31:0] FIN_A2_ADD   = 32'd120501;
  localparam logic [31:0] FIN_LEN_MASK = 32'hFFFFFF;
  localparam logic [31:0] FIN_LEN_ADD  = 32'd11;

  function automatic logic [31:0] sext8(input logic [BYTE_BITS-1:0] b);
    return {{(32-BYTE_BITS){b[BYTE_BITS-1]}}, b};
  endfunction

  logic [31:0]            acc_one;
  logic [31:0]            acc_two;
  logic [BYTE_BITS-1:0]   group_bytes [4];
  logic                   fin_pending;
  logic [LENGTH_BITS-1:0] fin_length;
  logic                   out_valid;
  logic [HASH_BITS-1:0]   out_hash;

  logic                   fin_fire;
  logic [31:0]            a1_in;
  logic [31:0]            a2_in;
  logic [31:0]            s_cur;
  logic [31:0]            acc_one_next;
  logic [31:0]            acc_two_next;
  logic [31:0]            fin_mix;
  logic [HASH_BITS-1:0]   fin_hash;

  assign out_res.valid      = out_valid;
  assign out_res.hash_value = out_hash;

  // finish moves to the output register when it is free or being drained
  assign fin_fire = fin_pending && (!out_valid || out_res.ready);
  assign pop      = pop_valid && (!fin_pending || fin_fire);

  // accumulator update for one byte request
  always_comb begin
    a1_in        = cmd.seed ? 32'(cmd.seed_rem) : acc_one;
    a2_in        = cmd.seed ? 32'(cmd.seed_len) : acc_two;
    s_cur        = sext8(cmd.byte_value);
    acc_one_next = a1_in;
    acc_two_next = a2_in;
    if (cmd.proc) begin
      if (cmd.full) begin
        if (cmd.pos == 2'd3) begin
          acc_one_next = (FULL_A2_MUL * a2_in + FULL_S0_MUL * sext8(group_bytes[0]))
                         ^ (FULL_S1_MUL * sext8(group_bytes[1]));
          acc_two_next = (FULL_CNT_MUL * 32'(cmd.cnt) + FULL_CNT_ADD + FULL_B2_MUL * a2_in)
                         ^ (FULL_S2_MUL * sext8(group_bytes[2]) + FULL_S3_MUL * s_cur
                            + FULL_S3_ADD);
        end
      end else begin
        case (cmd.pos)
          2'd0:    acc_one_next = (a1_in * T0_ACC_MUL) ^ (T0_S_MUL * s_cur);
          2'd1:    acc_two_next = (a2_in * T1_ACC_MUL) ^ (T1_S_MUL * s_cur);
          2'd2:    acc_one_next = (a1_in * T2_ACC_MUL) ^ (T2_ADD + T2_S_MUL * s_cur);
          default: acc_two_next = (a2_in * T3_ACC_MUL + T3_ACC_ADD)
                                  ^ (T3_ADD + T3_S_MUL * s_cur);
        endcase
      end
    end
  end

  // final hash with the zero fallbacks
  always_comb begin
    fin_mix = (acc_one * FIN_A1_MUL + FIN_A1_ADD) ^ (acc_two * FIN_A2_MUL + FIN_A2_ADD);
    if (fin_mix != '0) begin
      fin_hash = fin_mix;
    end else if (acc_one != '0) begin
      fin_hash = acc_one;
    end else if (acc_two != '0) begin
      fin_hash = acc_two;
    end else begin
      fin_hash = (32'(fin_length) & FIN_LEN_MASK) + FIN_LEN_ADD;
    end
  end

  // group byte store, written at the byte's place in its group
  always_ff @(posedge clk) begin
    if (pop && cmd.proc) begin
      group_bytes[cmd.pos] <= cmd.byte_value;
    end
  end

  // accumulators and finish flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_one     <= '0;
      acc_two     <= '0;
      fin_pending <= 1'b0;
    end else begin
      if (pop) begin
        acc_one <= acc_one_next;
        acc_two <= acc_two_next;
      end
      if (pop && cmd.emit) begin
        fin_pending <= 1'b1;
      end else if (fin_fire) begin
        fin_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.emit) begin
      fin_length <= cmd.total_length;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_hash <= fin_hash;
    end
  end

  a_hash_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_hash != '0))
    else $error("zero hash presented");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!fin_pending || fin_fire))
    else $error("request taken while a finish is still blocked");

endmodule

[sv/string_hash_four_byte_mix_top.sv]
// String hash with four-byte group mixing.
// Input channel in_req (shfm_in_if): one string byte per request; start_string
// marks the first byte of a string and carries string_length. An empty string
// is a single start request whose byte is ignored. A start request abandons any
// unfinished string. Bytes with start_string low and no string open are dropped.
// Output channel out_res (shfm_out_if): one nonzero 32-bit hash_value per string.
// Throughput: one byte per cycle sustained while out_res is not held; the front
// classifies each byte, a four-entry command queue decouples it from the back,
// which mixes groups into both accumulators, tail bytes into one, then hashes.
// Path: the last byte (or empty-string start) passes the queue slot, then the
// accumulators and finish flag, then the output register, if no stall intervenes.
// Stalls: while out_res is held, the back keeps at most one finished hash in
// its output register and one pending; further bytes fill the queue, then
// in_req.ready drops until the receiver takes the hash.
// Reset: rst (synchronous, active high) empties the queue and output register
// and closes any open string; no clearing pass is needed.
// Depends on shfm_pkg, shfm_in_if, shfm_out_if, shfm_front, shfm_queue, shfm_back.
module string_hash_four_byte_mix_top (
  input  logic        clk,
  input  logic        rst,
  shfm_in_if.sink     in_req,
  shfm_out_if.source  out_res
);
  import shfm_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic pop_valid;
  cmd_t pop_cmd;

  // classify incoming bytes
  shfm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_req (in_req),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  // decoupling queue
  shfm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_cmd)
  );

  // mixing and hash output
  shfm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .cmd       (pop_cmd),
    .pop       (pop),
    .out_res   (out_res)
  );

endmodule
